// ----- sv/gravity_acceleration_accumulator_macros.svh -----
// ----------------------------------------------------------------------------
// Gravity acceleration accumulator assertion macros
// Shared assertion forms for the checker. They expect clk and rst in scope.
// ----------------------------------------------------------------------------
`ifndef GRAVITY_ACCELERATION_ACCUMULATOR_MACROS_SVH
`define GRAVITY_ACCELERATION_ACCUMULATOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define GAA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define GAA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/gaa_pkg.sv -----
// ----------------------------------------------------------------------------
// Gravity acceleration accumulator package
// Widths, controller states and the command and status groups.
// ----------------------------------------------------------------------------
package gaa_pkg;

  localparam int COORD_W    = 32;
  localparam int ACC_W      = 48;
  localparam int AXES       = 3;
  localparam int MAG_W      = COORD_W;
  localparam int LIMB_W     = 32;
  localparam int R2_W       = 2 * MAG_W + 2;
  localparam int SQ_SHIFT   = 32;
  localparam int SQ_W       = (R2_W + SQ_SHIFT) / 2;
  localparam int X_W        = 2 * SQ_W;
  localparam int SREM_W     = SQ_W + 2;
  localparam int DEN_W      = R2_W + SQ_W;
  localparam int PROD_W     = 2 * LIMB_W;
  localparam int NUM_SHIFT  = 56;
  localparam int NUM_W      = PROD_W + NUM_SHIFT;
  localparam int QB_W       = ACC_W - 1;
  localparam int DSH_W      = DEN_W + QB_W;
  localparam int R2_PAD     = 3 * LIMB_W;
  localparam int SQ_PAD     = 2 * LIMB_W;
  localparam int MUL_OPS    = 6;
  localparam int SEL_W      = 3;
  localparam int CNT_W      = 6;

  localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {QB_W{1'b1}}};
  localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {QB_W{1'b0}}};

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL1,
    ST_CHECK,
    ST_SQRT,
    ST_MUL2,
    ST_DINIT,
    ST_DIV,
    ST_ACC,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic             load;
    logic             mul_issue;
    logic             mul_acc;
    logic             mul_phase;
    logic [SEL_W-1:0] mul_sel;
    logic             sqrt_init;
    logic             sqrt_step;
    logic             set_overlap;
    logic             div_init;
    logic             div_step;
    logic             accum;
    logic             emit;
  } cmd_t;

  typedef struct packed {
    logic r2_zero;
    logic out_free;
  } status_t;

endpackage

// ----- sv/gaa_div_lane.sv -----
// ----------------------------------------------------------------------------
// Gravity acceleration divider lane
// Restoring division of one axis numerator by the shared shifted denominator.
// ----------------------------------------------------------------------------
module gaa_div_lane (
  input  logic                       clk,
  input  logic                       init,
  input  logic                       step,
  input  logic [gaa_pkg::PROD_W-1:0] num,
  input  logic [gaa_pkg::DSH_W-1:0]  den_sh,
  output logic [gaa_pkg::QB_W-1:0]   mag,
  output logic                       sat
);
  import gaa_pkg::*;

  logic [NUM_W-1:0] rem;
  logic [ACC_W-1:0] q;
  logic             ge;

  assign ge  = DSH_W'(rem) >= den_sh;
  assign sat = q[ACC_W-1];
  assign mag = sat ? {QB_W{1'b1}} : q[QB_W-1:0];

  always_ff @(posedge clk) begin
    if (init) begin
      rem <= {num, {NUM_SHIFT{1'b0}}};
      q   <= '0;
    end else if (step) begin
      if (ge) begin
        rem <= rem - den_sh[NUM_W-1:0];
      end
      q <= {q[ACC_W-2:0], ge};
    end
  end

endmodule

// ----- sv/gaa_dp.sv -----
// ----------------------------------------------------------------------------
// Gravity acceleration datapath
// Shared multiplier, square root, divider lanes, sums and output register.
// ----------------------------------------------------------------------------
module gaa_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  gaa_pkg::cmd_t                      cmd,
  output gaa_pkg::status_t                   status,
  input  logic signed [gaa_pkg::COORD_W-1:0] self_x,
  input  logic signed [gaa_pkg::COORD_W-1:0] self_y,
  input  logic signed [gaa_pkg::COORD_W-1:0] self_z,
  input  logic signed [gaa_pkg::COORD_W-1:0] src_x,
  input  logic signed [gaa_pkg::COORD_W-1:0] src_y,
  input  logic signed [gaa_pkg::COORD_W-1:0] src_z,
  input  logic        [gaa_pkg::COORD_W-1:0] src_mu,
  input  logic                               out_ready,
  output logic                               out_valid,
  output logic signed [gaa_pkg::ACC_W-1:0]   acc_x,
  output logic signed [gaa_pkg::ACC_W-1:0]   acc_y,
  output logic signed [gaa_pkg::ACC_W-1:0]   acc_z,
  output logic                               overlap_seen,
  output logic                               saturated
);
  import gaa_pkg::*;

  logic signed [COORD_W:0]   diff [AXES];
  logic signed [COORD_W:0]   ndiff [AXES];
  logic [MAG_W-1:0]          dabs [AXES];
  logic                      dneg [AXES];
  logic [COORD_W-1:0]        mu;

  logic [LIMB_W-1:0]         mul_a;
  logic [LIMB_W-1:0]         mul_b;
  logic [1:0]                iss_ax;
  logic [R2_PAD-1:0]         r2_pad;
  logic [SQ_PAD-1:0]         sq_pad;
  logic [PROD_W-1:0]         prod;
  logic                      prod_phase;
  logic [SEL_W-1:0]          prod_sel;
  logic [1:0]                prod_ax;

  logic [R2_W-1:0]           r2;
  logic [PROD_W-1:0]         pnum [AXES];
  logic [X_W-1:0]            sx;
  logic [SREM_W-1:0]         srem;
  logic [SQ_W-1:0]           root;
  logic [SREM_W+1:0]         rem_sh;
  logic [SREM_W+1:0]         trial;
  logic [DEN_W-1:0]          den;
  logic [DSH_W-1:0]          den_sh;

  logic [QB_W-1:0]           mag [AXES];
  logic                      lane_sat [AXES];
  logic signed [ACC_W-1:0]   sum [AXES];
  logic signed [ACC_W-1:0]   sum_next [AXES];
  logic                      ovf [AXES];
  logic signed [ACC_W:0]     term [AXES];
  logic signed [ACC_W:0]     tot [AXES];
  logic                      overlap_flag;
  logic                      sat_flag;

  assign diff[0] = {src_x[COORD_W-1], src_x} - {self_x[COORD_W-1], self_x};
  assign diff[1] = {src_y[COORD_W-1], src_y} - {self_y[COORD_W-1], self_y};
  assign diff[2] = {src_z[COORD_W-1], src_z} - {self_z[COORD_W-1], self_z};

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      ndiff[a] = -diff[a];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int a = 0; a < AXES; a++) begin
        dneg[a] <= diff[a][COORD_W];
        dabs[a] <= diff[a][COORD_W] ? ndiff[a][MAG_W-1:0] : diff[a][MAG_W-1:0];
      end
      mu <= src_mu;
    end
  end

  assign r2_pad = R2_PAD'(r2);
  assign sq_pad = SQ_PAD'(root);
  assign iss_ax = (cmd.mul_sel < SEL_W'(AXES)) ? cmd.mul_sel[1:0]
                                                : 2'(cmd.mul_sel - SEL_W'(AXES));
  assign prod_ax = (prod_sel < SEL_W'(AXES)) ? prod_sel[1:0]
                                              : 2'(prod_sel - SEL_W'(AXES));

  always_comb begin
    if (cmd.mul_phase) begin
      mul_a = r2_pad[cmd.mul_sel[2:1] * LIMB_W +: LIMB_W];
      mul_b = sq_pad[cmd.mul_sel[0] * LIMB_W +: LIMB_W];
    end else begin
      mul_a = (cmd.mul_sel < SEL_W'(AXES)) ? dabs[iss_ax] : mu;
      mul_b = dabs[iss_ax];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_issue) begin
      prod       <= mul_a * mul_b;
      prod_phase <= cmd.mul_phase;
      prod_sel   <= cmd.mul_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r2 <= '0;
    end else if (cmd.mul_acc && !prod_phase && prod_sel < SEL_W'(AXES)) begin
      r2 <= r2 + R2_W'(prod);
    end
    if (cmd.mul_acc && !prod_phase && prod_sel >= SEL_W'(AXES)) begin
      pnum[prod_ax] <= prod;
    end
    if (cmd.sqrt_init) begin
      den <= '0;
    end else if (cmd.mul_acc && prod_phase) begin
      den <= den + (DEN_W'(prod) << (LIMB_W * (prod_sel[2:1] + prod_sel[0])));
    end
  end

  assign rem_sh = {srem, sx[X_W-1:X_W-2]};
  assign trial  = (SREM_W+2)'({root, 2'b01});

  always_ff @(posedge clk) begin
    if (cmd.sqrt_init) begin
      sx   <= {r2, {SQ_SHIFT{1'b0}}};
      srem <= '0;
      root <= '0;
    end else if (cmd.sqrt_step) begin
      sx <= {sx[X_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        srem <= SREM_W'(rem_sh - trial);
        root <= {root[SQ_W-2:0], 1'b1};
      end else begin
        srem <= SREM_W'(rem_sh);
        root <= {root[SQ_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      den_sh <= DSH_W'(den) << QB_W;
    end else if (cmd.div_step) begin
      den_sh <= den_sh >> 1;
    end
  end

  for (genvar g = 0; g < AXES; g++) begin : g_lane
    gaa_div_lane u_lane (
      .clk    (clk),
      .init   (cmd.div_init),
      .step   (cmd.div_step),
      .num    (pnum[g]),
      .den_sh (den_sh),
      .mag    (mag[g]),
      .sat    (lane_sat[g])
    );
  end

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      term[a]     = dneg[a] ? -$signed({2'b00, mag[a]}) : $signed({2'b00, mag[a]});
      tot[a]      = $signed({sum[a][ACC_W-1], sum[a]}) + term[a];
      ovf[a]      = tot[a][ACC_W] != tot[a][ACC_W-1];
      sum_next[a] = ovf[a] ? (tot[a][ACC_W] ? $signed(ACC_MIN) : $signed(ACC_MAX))
                           : tot[a][ACC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < AXES; a++) begin
        sum[a] <= '0;
      end
      overlap_flag <= 1'b0;
      sat_flag     <= 1'b0;
    end else if (cmd.emit) begin
      for (int a = 0; a < AXES; a++) begin
        sum[a] <= '0;
      end
      overlap_flag <= 1'b0;
      sat_flag     <= 1'b0;
    end else begin
      if (cmd.accum) begin
        for (int a = 0; a < AXES; a++) begin
          sum[a] <= sum_next[a];
        end
        if (lane_sat[0] || lane_sat[1] || lane_sat[2] || ovf[0] || ovf[1] || ovf[2]) begin
          sat_flag <= 1'b1;
        end
      end
      if (cmd.set_overlap) begin
        overlap_flag <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      acc_x        <= sum[0];
      acc_y        <= sum[1];
      acc_z        <= sum[2];
      overlap_seen <= overlap_flag;
      saturated    <= sat_flag;
    end
  end

  assign status.r2_zero  = r2 == '0;
  assign status.out_free = !out_valid || out_ready;

endmodule

// ----- sv/gaa_ctrl.sv -----
// ----------------------------------------------------------------------------
// Gravity acceleration controller
// Sequences the multiply, square root, divide and accumulate phases.
// ----------------------------------------------------------------------------
module gaa_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             has_attractor,
  input  logic             last_item,
  input  gaa_pkg::status_t status,
  output logic             in_ready,
  output gaa_pkg::cmd_t    cmd
);
  import gaa_pkg::*;

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic             last_q;
  logic             last_q_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      cnt    <= '0;
      last_q <= 1'b0;
    end else begin
      state  <= state_next;
      cnt    <= cnt_next;
      last_q <= last_q_next;
    end
  end

  always_comb begin
    state_next  = state;
    cnt_next    = '0;
    last_q_next = last_q;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          last_q_next = last_item;
          state_next  = has_attractor ? ST_MUL1 : ST_EMIT;
        end
      end
      ST_MUL1: begin
        if (cnt == CNT_W'(MUL_OPS)) begin
          state_next = ST_CHECK;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_CHECK: begin
        state_next = status.r2_zero ? ST_EMIT : ST_SQRT;
      end
      ST_SQRT: begin
        if (cnt == CNT_W'(SQ_W - 1)) begin
          state_next = ST_MUL2;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_MUL2: begin
        if (cnt == CNT_W'(MUL_OPS)) begin
          state_next = ST_DINIT;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_DINIT: begin
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (cnt == CNT_W'(ACC_W - 1)) begin
          state_next = ST_ACC;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_ACC: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (!last_q || status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_MUL1, ST_MUL2: begin
        cmd.mul_phase = state == ST_MUL2;
        cmd.mul_issue = cnt < CNT_W'(MUL_OPS);
        cmd.mul_acc   = cnt != '0;
        cmd.mul_sel   = cnt[SEL_W-1:0];
      end
      ST_CHECK: begin
        cmd.set_overlap = status.r2_zero;
        cmd.sqrt_init   = !status.r2_zero;
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
      end
      ST_DINIT: begin
        cmd.div_init = 1'b1;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      ST_ACC: begin
        cmd.accum = 1'b1;
      end
      ST_EMIT: begin
        cmd.emit = last_q && status.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ----- sv/gravity_acceleration_accumulator.sv -----
// ----------------------------------------------------------------------------
// Gravity acceleration accumulator
// Sums mu * d / |d|^3 over attractors and emits the sum on the last request.
//
//   Channel  Direction  Handshake             Payload
//   in       input      in_valid / in_ready   positions, mu, has_attractor, last_item
//   out      output     out_valid / out_ready acc_x, acc_y, acc_z, flags
//
// A request with an attractor occupies the block while the shared 32x32
// multiplier runs twice and the square root and the three divider lanes run.
// A zero distance ends after the check. A request without an attractor goes
// straight to the final state.
// Reset is synchronous and clears the sums, the flags and the controller.
// A last request waits in its final state while the output register is full.
// ----------------------------------------------------------------------------
module gravity_acceleration_accumulator (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [gaa_pkg::COORD_W-1:0] self_x,
  input  logic signed [gaa_pkg::COORD_W-1:0] self_y,
  input  logic signed [gaa_pkg::COORD_W-1:0] self_z,
  input  logic signed [gaa_pkg::COORD_W-1:0] src_x,
  input  logic signed [gaa_pkg::COORD_W-1:0] src_y,
  input  logic signed [gaa_pkg::COORD_W-1:0] src_z,
  input  logic        [gaa_pkg::COORD_W-1:0] src_mu,
  input  logic                               has_attractor,
  input  logic                               last_item,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [gaa_pkg::ACC_W-1:0]   acc_x,
  output logic signed [gaa_pkg::ACC_W-1:0]   acc_y,
  output logic signed [gaa_pkg::ACC_W-1:0]   acc_z,
  output logic                               overlap_seen,
  output logic                               saturated
);
  import gaa_pkg::*;

  cmd_t    cmd;
  status_t status;

  gaa_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .has_attractor (has_attractor),
    .last_item     (last_item),
    .status        (status),
    .in_ready      (in_ready),
    .cmd           (cmd)
  );

  gaa_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .self_x       (self_x),
    .self_y       (self_y),
    .self_z       (self_z),
    .src_x        (src_x),
    .src_y        (src_y),
    .src_z        (src_z),
    .src_mu       (src_mu),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .acc_x        (acc_x),
    .acc_y        (acc_y),
    .acc_z        (acc_z),
    .overlap_seen (overlap_seen),
    .saturated    (saturated)
  );

endmodule

// ----- sv/gaa_checker.sv -----
// ----------------------------------------------------------------------------
// Gravity acceleration accumulator checker
// Port-level temporal checks, bound to the top level.
// ----------------------------------------------------------------------------
`include "gravity_acceleration_accumulator_macros.svh"

module gaa_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic signed [gaa_pkg::COORD_W-1:0] self_x,
  input logic signed [gaa_pkg::COORD_W-1:0] self_y,
  input logic signed [gaa_pkg::COORD_W-1:0] self_z,
  input logic signed [gaa_pkg::COORD_W-1:0] src_x,
  input logic signed [gaa_pkg::COORD_W-1:0] src_y,
  input logic signed [gaa_pkg::COORD_W-1:0] src_z,
  input logic        [gaa_pkg::COORD_W-1:0] src_mu,
  input logic                               has_attractor,
  input logic                               last_item,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [gaa_pkg::ACC_W-1:0]   acc_x,
  input logic signed [gaa_pkg::ACC_W-1:0]   acc_y,
  input logic signed [gaa_pkg::ACC_W-1:0]   acc_z,
  input logic                               overlap_seen,
  input logic                               saturated
);

  `GAA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(acc_x) && $stable(acc_y) && $stable(acc_z), "result changed while stalled")
  `GAA_ASSERT_NOW(a_out_drop, $fell(out_valid), $past(out_ready), "result dropped without acceptance")
  `GAA_ASSERT_NEXT(a_busy, in_valid && in_ready && has_attractor, !in_ready, "accepted a request while computing")
  `GAA_ASSERT_NEXT(a_skip, in_valid && in_ready && !has_attractor && !last_item, !in_ready ##1 in_ready, "empty request took the wrong time")
  `GAA_ASSERT_NOW(a_emit, in_valid && in_ready && !has_attractor && last_item && !out_valid, ##2 out_valid, "sum not emitted on a last request")

endmodule

bind gravity_acceleration_accumulator gaa_checker u_gaa_checker (.*);
